@@ hdl/page_mode_framebuffer_blitter_macros.svh @@
// -----------------------------------------------------------------------------
// page_mode_framebuffer_blitter_macros.svh
// Assertion macros shared by the command queue and back end. Clock aclk, reset aresetn.
// -----------------------------------------------------------------------------
`ifndef PAGE_MODE_FRAMEBUFFER_BLITTER_MACROS_SVH
`define PAGE_MODE_FRAMEBUFFER_BLITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pmfb_pkg.sv @@
// -----------------------------------------------------------------------------
// pmfb_pkg
// Types and codes shared by the front end, command queue and back end.
// -----------------------------------------------------------------------------
package pmfb_pkg;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    // Input word modes
    localparam logic [2:0] MODE_PIX_WRITE  = 3'd0;
    localparam logic [2:0] MODE_PIX_READ   = 3'd1;
    localparam logic [2:0] MODE_CLEAR      = 3'd2;
    localparam logic [2:0] MODE_BLIT_START = 3'd3;
    localparam logic [2:0] MODE_BLIT_DATA  = 3'd4;

    typedef enum logic [1:0] {
        CMD_SPAN,
        CMD_READ,
        CMD_CLEAR
    } cmd_op_t;

    // One queued job for the back end. A span touches up to eight
    // neighboring columns of one page, all at the same bit.
    typedef struct packed {
        cmd_op_t     op;
        logic        hit;        // read lands on the panel
        logic        color;
        logic [3:0]  act_pages;  // pages to clear
        logic [3:0]  page;
        logic [2:0]  bit_sel;
        logic [8:0]  base_col;
        logic [7:0]  pix_mask;   // bit i draws column base_col + i
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SPAN,
        BK_READ,
        BK_READ_DONE,
        BK_CLEAR
    } back_state_t;

endpackage

@@ hdl/pmfb_front.sv @@
// -----------------------------------------------------------------------------
// pmfb_front
// Accepts input words, clips them and turns them into back-end commands.
// Holds the panel height register and the blit cursor.
// -----------------------------------------------------------------------------
module pmfb_front #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int MAX_ROWS       = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pmfb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             cfg_we,
    input  logic [6:0]                       cfg_wdata,
    input  logic                             init_done,
    input  logic                             q_full,
    output logic                             q_push,
    output pmfb_pkg::cmd_t                   q_push_cmd
);
    import pmfb_pkg::*;

    localparam int PAGES = MAX_ROWS / 8;

    logic [6:0] ph_reg, ph_next;
    logic [7:0] org_col_reg, org_col_next;
    logic [7:0] org_row_reg, org_row_next;
    logic [7:0] bw_reg, bw_next;
    logic [7:0] bh_reg, bh_next;
    logic       bcolor_reg, bcolor_next;
    logic [4:0] bir_reg, bir_next;
    logic [7:0] row_cnt_reg, row_cnt_next;

    logic [2:0] f_mode;
    logic [7:0] f_x, f_y, f_w, f_h, f_data;
    logic       f_color;
    logic       accept;
    logic [3:0] act_pages;
    logic       pix_hit;
    logic       blit_on;
    logic [8:0] y_abs;
    logic       y_hit;
    logic [8:0] blit_base;
    logic [7:0] blit_mask;
    logic [5:0] per_row;
    logic [5:0] bir_inc;
    logic [7:0] bx;
    logic [8:0] colv;

    assign f_mode  = s_tdata[2:0];
    assign f_x     = s_tdata[10:3];
    assign f_y     = s_tdata[18:11];
    assign f_color = s_tdata[19];
    assign f_w     = s_tdata[27:20];
    assign f_h     = s_tdata[35:28];
    assign f_data  = s_tdata[43:36];

    assign s_tready = init_done && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        bx = 8'd0;
        colv = 9'd0;
        // drop height bits below a page, saturate at the store height
        if ({1'b0, ph_reg[6:3]} > 5'(PAGES)) begin
            act_pages = 4'(PAGES);
        end else begin
            act_pages = ph_reg[6:3];
        end
        pix_hit = ({1'b0, f_x} < 9'(SCREEN_COLUMNS)) && ({1'b0, f_y[7:3]} < {2'b0, act_pages});

        blit_on   = (bw_reg != 8'd0) && (row_cnt_reg < bh_reg);
        y_abs     = {1'b0, org_row_reg} + {1'b0, row_cnt_reg};
        y_hit     = y_abs[8:3] < {2'b0, act_pages};
        blit_base = {1'b0, org_col_reg} + {1'b0, bir_reg, 3'b000};
        for (int i = 0; i < 8; i++) begin
            bx = {bir_reg, 3'(i)};
            colv = blit_base + 9'(i);
            blit_mask[i] = f_data[7 - i] && (bx < bw_reg) && (colv < 9'(SCREEN_COLUMNS))
                           && y_hit && blit_on;
        end
        per_row = 6'(({1'b0, bw_reg} + 9'd7) >> 3);
        bir_inc = {1'b0, bir_reg} + 6'd1;

        ph_next      = ph_reg;
        org_col_next = org_col_reg;
        org_row_next = org_row_reg;
        bw_next      = bw_reg;
        bh_next      = bh_reg;
        bcolor_next  = bcolor_reg;
        bir_next     = bir_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_we) begin
            ph_next = cfg_wdata;
        end

        q_push = 1'b0;
        q_push_cmd.op        = CMD_SPAN;
        q_push_cmd.hit       = pix_hit;
        q_push_cmd.color     = f_color;
        q_push_cmd.act_pages = act_pages;
        q_push_cmd.page      = f_y[6:3];
        q_push_cmd.bit_sel   = f_y[2:0];
        q_push_cmd.base_col  = {1'b0, f_x};
        q_push_cmd.pix_mask  = 8'h01;

        if (accept) begin
            case (f_mode)
                MODE_PIX_WRITE: begin
                    q_push = pix_hit;
                end
                MODE_PIX_READ: begin
                    q_push = 1'b1;
                    q_push_cmd.op = CMD_READ;
                end
                MODE_CLEAR: begin
                    q_push = 1'b1;
                    q_push_cmd.op = CMD_CLEAR;
                end
                MODE_BLIT_START: begin
                    org_col_next = f_x;
                    org_row_next = f_y;
                    bw_next      = f_w;
                    bh_next      = f_h;
                    bcolor_next  = f_color;
                    bir_next     = 5'd0;
                    row_cnt_next = 8'd0;
                end
                MODE_BLIT_DATA: begin
                    q_push = |blit_mask;
                    q_push_cmd.color    = bcolor_reg;
                    q_push_cmd.page     = y_abs[6:3];
                    q_push_cmd.bit_sel  = y_abs[2:0];
                    q_push_cmd.base_col = blit_base;
                    q_push_cmd.pix_mask = blit_mask;
                    // advance the cursor, wrap to the next row at the padded width
                    if (blit_on) begin
                        if (bir_inc >= per_row) begin
                            bir_next     = 5'd0;
                            row_cnt_next = row_cnt_reg + 8'd1;
                        end else begin
                            bir_next = bir_inc[4:0];
                        end
                    end
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= 7'd64;
            org_col_reg <= 8'd0;
            org_row_reg <= 8'd0;
            bw_reg      <= 8'd0;
            bh_reg      <= 8'd0;
            bcolor_reg  <= 1'b0;
            bir_reg     <= 5'd0;
            row_cnt_reg <= 8'd0;
        end else begin
            ph_reg      <= ph_next;
            org_col_reg <= org_col_next;
            org_row_reg <= org_row_next;
            bw_reg      <= bw_next;
            bh_reg      <= bh_next;
            bcolor_reg  <= bcolor_next;
            bir_reg     <= bir_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

@@ hdl/pmfb_cmd_fifo.sv @@
// -----------------------------------------------------------------------------
// pmfb_cmd_fifo
// Short command queue between the front end and the back end.
// -----------------------------------------------------------------------------
`include "page_mode_framebuffer_blitter_macros.svh"

module pmfb_cmd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pmfb_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output pmfb_pkg::cmd_t    pop_cmd,
    output logic              empty
);
    import pmfb_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `PMFB_ASSERT_NOW(a_no_push_when_full, push, !full, "command pushed into a full queue")
    `PMFB_ASSERT_NOW(a_no_pop_when_empty, pop, !empty, "command popped from an empty queue")
    `PMFB_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

@@ hdl/pmfb_back.sv @@
// -----------------------------------------------------------------------------
// pmfb_back
// Executes queued commands on the frame store: read-modify-write spans,
// pixel reads into the result register, and page clears. Clears the whole
// store after reset before the first command is taken.
// -----------------------------------------------------------------------------
`include "page_mode_framebuffer_blitter_macros.svh"

module pmfb_back #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int MAX_ROWS       = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  pmfb_pkg::cmd_t                   q_head,
    output logic                             q_pop,
    output logic                             init_done,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pmfb_pkg::M_TDATA_W-1:0]   m_tdata
);
    import pmfb_pkg::*;

    localparam int STORE_BYTES = SCREEN_COLUMNS * (MAX_ROWS / 8);
    localparam int AW          = $clog2(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] mem_rdata_reg;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [2:0]  idx_reg, idx_next;
    logic [AW-1:0] addr_cnt_reg, addr_cnt_next;
    logic [AW-1:0] clr_last_reg, clr_last_next;
    logic        fill_reg, fill_next;
    logic        init_done_reg, init_done_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_data_reg, out_data_next;

    logic [8:0]    span_col;
    logic [AW-1:0] span_addr;
    logic          span_last;
    logic          mem_re;
    logic          clr_we;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    bit_mask;

    assign init_done = init_done_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-1){1'b0}}, out_data_reg};

    assign span_col  = cmd_reg.base_col + {6'd0, idx_reg};
    assign span_addr = AW'(int'(cmd_reg.page) * SCREEN_COLUMNS + int'(span_col));
    // stop once no marked column remains above the current one
    assign span_last = (idx_reg == 3'd7) || (((cmd_reg.pix_mask >> idx_reg) >> 1) == 8'd0);
    assign bit_mask  = 8'd1 << cmd_reg.bit_sel;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        addr_cnt_next   = addr_cnt_reg;
        clr_last_next   = clr_last_reg;
        fill_next       = fill_reg;
        init_done_next  = init_done_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;
        mem_re          = 1'b0;
        clr_we          = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    idx_next = 3'd0;
                    case (q_head.op)
                        CMD_SPAN: begin
                            state_next = BK_SPAN;
                        end
                        CMD_READ: begin
                            state_next = BK_READ;
                        end
                        CMD_CLEAR: begin
                            if (q_head.act_pages != 4'd0) begin
                                state_next    = BK_CLEAR;
                                addr_cnt_next = '0;
                                clr_last_next = AW'(int'(q_head.act_pages) * SCREEN_COLUMNS - 1);
                                fill_next     = q_head.color;
                            end
                        end
                        default: begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_SPAN: begin
                // read this column now, write it back next cycle
                if (cmd_reg.pix_mask[idx_reg]) begin
                    mem_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = span_addr;
                end
                idx_next = idx_reg + 3'd1;
                if (span_last) begin
                    state_next = BK_IDLE;
                end
            end
            BK_READ: begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready) begin
                    mem_re     = cmd_reg.hit;
                    state_next = BK_READ_DONE;
                end
            end
            BK_READ_DONE: begin
                out_valid_next = 1'b1;
                out_data_next  = cmd_reg.hit && mem_rdata_reg[cmd_reg.bit_sel];
                state_next     = BK_IDLE;
            end
            BK_CLEAR: begin
                clr_we        = 1'b1;
                addr_cnt_next = addr_cnt_reg + 1'b1;
                if (addr_cnt_reg == clr_last_reg) begin
                    state_next     = BK_IDLE;
                    init_done_next = 1'b1;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we    = clr_we || pend_valid_reg;
        mem_waddr = clr_we ? addr_cnt_reg : pend_addr_reg;
        if (clr_we) begin
            mem_wdata = {8{fill_reg}};
        end else if (cmd_reg.color) begin
            mem_wdata = mem_rdata_reg | bit_mask;
        end else begin
            mem_wdata = mem_rdata_reg & ~bit_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[span_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_CLEAR;
            idx_reg        <= 3'd0;
            addr_cnt_reg   <= '0;
            clr_last_reg   <= AW'(STORE_BYTES - 1);
            fill_reg       <= 1'b0;
            init_done_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            addr_cnt_reg   <= addr_cnt_next;
            clr_last_reg   <= clr_last_next;
            fill_reg       <= fill_next;
            init_done_reg  <= init_done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        pend_addr_reg <= pend_addr_next;
        out_data_reg  <= out_data_next;
    end

    `PMFB_ASSERT_NOW(a_rmw_not_in_clear, pend_valid_reg, state_reg != BK_CLEAR, "write-back overlaps a clear sweep")
    `PMFB_ASSERT_NOW(a_result_slot_free, state_reg == BK_READ_DONE, !out_valid_reg, "read result would overwrite a pending word")
    `PMFB_ASSERT_NOW(a_init_sweep_first, !init_done_reg, state_reg == BK_CLEAR, "command taken before the reset clear finished")
    `PMFB_ASSERT_NEXT(a_result_from_read, !out_valid_reg && state_reg != BK_READ_DONE, !out_valid_reg, "result word appeared without a read")

endmodule

@@ hdl/page_mode_framebuffer_blitter.sv @@
// -----------------------------------------------------------------------------
// page_mode_framebuffer_blitter
// 1 bpp page-layout frame store with pixel write/read, clear and bitmap blit.
// -----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready/s_tdata; each carries a mode
// (pixel write, pixel read, clear, blit start, blit data byte) and its fields.
// Only a pixel read returns a word, on m_tvalid/m_tready/m_tdata, in order.
// cfg_we/cfg_wdata load the active panel height; write it only while idle.
// The front end takes one word per cycle while the command queue (4 deep)
// has room; the back end then runs each command against a single-port-write,
// single-port-read byte store with registered read data:
//   pixel write   a store read, then the write-back
//   pixel read    waits until the result register is free, then a store read to the result word
//   blit byte     one store read per marked column, each
//                 write-back overlapped with the next column's read
//   clear         pages * SCREEN_COLUMNS bytes, one byte per cycle
//   blit start    front end only, no back-end time
// After reset the store is swept to zero, all SCREEN_COLUMNS * MAX_ROWS / 8
// bytes (1024 by default); s_tready stays low until that sweep ends.
// A stalled receiver holds the result word; a later pixel read then waits,
// later commands back up in the queue and s_tready drops when it is full.
// -----------------------------------------------------------------------------
module page_mode_framebuffer_blitter #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int MAX_ROWS       = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // mode[2:0], pos_x[10:3], pos_y[18:11], color[19], blit_width[27:20],
    // blit_height[35:28], data_byte[43:36], zero pad [47:44]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pmfb_pkg::S_TDATA_W-1:0]   s_tdata,
    // pixel_value[0], zero pad [7:1]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pmfb_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [6:0]                       cfg_wdata
);
    import pmfb_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_push_cmd, q_head;
    logic init_done;

    pmfb_front #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .init_done (init_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_push_cmd(q_push_cmd)
    );

    pmfb_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(q_push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .pop_cmd (q_head),
        .empty   (q_empty)
    );

    pmfb_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .init_done(init_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
